[sv/vgrt_pkg.sv]
// shared types and constants for the voxel ray traversal block
`timescale 1ns / 1ps
package vgrt_pkg;
	localparam int COORD_BITS = 11;
	localparam int FRAC_BITS = 8;
	localparam int DIST_BITS = 32;
	localparam int BLOCK_BITS = 8;
	localparam int ORIGIN_BITS = 19;
	localparam int DIR_BITS = 16;
	localparam int MAG_BITS = 15;
	localparam int QUOT_BITS = 31;
	localparam logic [DIST_BITS-1:0] DMAX = '1;

	localparam logic OP_START = 1'b0;
	localparam logic OP_ANSWER = 1'b1;

	localparam logic [2:0] FACE_PX = 3'd0;
	localparam logic [2:0] FACE_NX = 3'd1;
	localparam logic [2:0] FACE_PY = 3'd2;
	localparam logic [2:0] FACE_NY = 3'd3;
	localparam logic [2:0] FACE_PZ = 3'd4;
	localparam logic [2:0] FACE_NZ = 3'd5;

	typedef struct packed {
		logic load;       // latch start word, begin reciprocals
		logic div_step;   // one restoring division step on all axes
		logic side_init;  // compute initial side distances
		logic advance;    // one dda step
		logic check;      // distance test
	} vgrt_cmd_t;

	typedef struct packed {
		logic div_done;
		logic beyond;
	} vgrt_sts_t;
endpackage

[sv/vgrt_datapath.sv]
// datapath: cell, side and delta registers, serial divider, distance check
`timescale 1ns / 1ps
module vgrt_datapath import vgrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  vgrt_cmd_t cmd,
	output vgrt_sts_t sts,
	input  logic [7:0] max_reach,
	input  logic signed [ORIGIN_BITS-1:0] origin_x,
	input  logic signed [ORIGIN_BITS-1:0] origin_y,
	input  logic signed [ORIGIN_BITS-1:0] origin_z,
	input  logic signed [DIR_BITS-1:0] dir_x,
	input  logic signed [DIR_BITS-1:0] dir_y,
	input  logic signed [DIR_BITS-1:0] dir_z,
	output logic [COORD_BITS-1:0] cur_x,
	output logic [COORD_BITS-1:0] cur_y,
	output logic [COORD_BITS-1:0] cur_z,
	output logic [COORD_BITS-1:0] prv_x,
	output logic [COORD_BITS-1:0] prv_y,
	output logic [COORD_BITS-1:0] prv_z,
	output logic [2:0] face
);
	logic [2:0][COORD_BITS-1:0] cur_q, prv_q, base_q;
	logic [2:0][DIST_BITS-1:0] side_q, delta_q;
	logic [2:0] neg_q, zero_q;
	logic [2:0][FRAC_BITS-1:0] frac_q;
	logic [2:0][MAG_BITS:0] mag_q;
	logic [2:0][QUOT_BITS-1:0] quot_q;
	logic [2:0][MAG_BITS:0] rem_q;
	logic [4:0] cnt_q;
	logic [2:0][ORIGIN_BITS-1:0] o_in;
	logic [2:0][DIR_BITS-1:0] d_in;
	logic [1:0] axis;
	logic beyond_q;

	assign o_in = {origin_z, origin_y, origin_x};
	assign d_in = {dir_z, dir_y, dir_x};

	always_comb begin
		if (side_q[0] < side_q[2] && side_q[0] < side_q[1]) axis = 2'd0;
		else if (side_q[1] < side_q[0] && side_q[1] < side_q[2]) axis = 2'd1;
		else axis = 2'd2;
	end

	// squared distance from the start cell
	logic signed [2:0][COORD_BITS-1:0] diff;
	logic [2:0][2*COORD_BITS-1:0] sq;
	logic [2*COORD_BITS+1:0] sum;
	logic [17:0] cap;
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			diff[a] = cur_q[a] - base_q[a];
			sq[a] = (2*COORD_BITS)'($signed(diff[a]) * $signed(diff[a]));
		end
		sum = (2*COORD_BITS+2)'(sq[0]) + (2*COORD_BITS+2)'(sq[1])
			+ (2*COORD_BITS+2)'(sq[2]);
		cap = 18'(max_reach * max_reach) * 18'd3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			beyond_q <= 1'b0;
		end else begin
			if (cmd.load) cnt_q <= 5'(QUOT_BITS - 1);
			else if (cmd.div_step && cnt_q != '0) cnt_q <= cnt_q - 5'd1;
			if (cmd.check) beyond_q <= 32'(sum) > 32'(cap);
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			if (cmd.load) begin
				frac_q[a] <= o_in[a][FRAC_BITS-1:0];
				base_q[a] <= o_in[a][FRAC_BITS +: COORD_BITS];
				cur_q[a] <= o_in[a][FRAC_BITS +: COORD_BITS];
				neg_q[a] <= !($signed(d_in[a]) > 0);
				mag_q[a] <= d_in[a][DIR_BITS-1] ? (MAG_BITS+1)'(-d_in[a])
					: (MAG_BITS+1)'(d_in[a]);
				zero_q[a] <= d_in[a] == '0;
				quot_q[a] <= '0;
				rem_q[a] <= '0;
			end else if (cmd.div_step) begin
				// dividend is 2^30: one restoring step per cycle, msb first
				logic [MAG_BITS+1:0] r;
				r = {rem_q[a], (cnt_q == 5'd30)};
				if (r >= (MAG_BITS+2)'(mag_q[a]) && !zero_q[a]) begin
					rem_q[a] <= (MAG_BITS+1)'(r - (MAG_BITS+2)'(mag_q[a]));
					quot_q[a] <= {quot_q[a][QUOT_BITS-2:0], 1'b1};
				end else begin
					rem_q[a] <= r[MAG_BITS:0];
					quot_q[a] <= {quot_q[a][QUOT_BITS-2:0], 1'b0};
				end
			end else if (cmd.side_init) begin
				logic [DIST_BITS-1:0] dl;
				logic [FRAC_BITS:0] m;
				logic [DIST_BITS+FRAC_BITS:0] p;
				dl = zero_q[a] ? DMAX : DIST_BITS'(quot_q[a]);
				delta_q[a] <= dl;
				m = neg_q[a] ? (FRAC_BITS+1)'(frac_q[a])
					: (FRAC_BITS+1)'(1 << FRAC_BITS) - (FRAC_BITS+1)'(frac_q[a]);
				p = m * dl;
				side_q[a] <= p[FRAC_BITS +: DIST_BITS];
			end else if (cmd.advance && axis == 2'(a)) begin
				logic [DIST_BITS:0] s;
				s = {1'b0, side_q[a]} + {1'b0, delta_q[a]};
				side_q[a] <= s[DIST_BITS] ? DMAX : s[DIST_BITS-1:0];
				cur_q[a] <= neg_q[a] ? cur_q[a] - 1'b1 : cur_q[a] + 1'b1;
			end
			if (cmd.advance) prv_q[a] <= cur_q[a];
		end
	end

	always_comb begin
		logic [COORD_BITS-1:0] d;
		face = FACE_PX;
		for (int a = 0; a < 3; a++) begin
			d = prv_q[a] - cur_q[a];
			if (d == COORD_BITS'(1)) face = (a == 0) ? FACE_PX : (a == 1) ? FACE_PY : FACE_PZ;
			if (d == '1) face = (a == 0) ? FACE_NX : (a == 1) ? FACE_NY : FACE_NZ;
		end
	end

	assign sts.div_done = cnt_q == '0;
	assign sts.beyond = beyond_q;
	assign cur_x = cur_q[0];
	assign cur_y = cur_q[1];
	assign cur_z = cur_q[2];
	assign prv_x = prv_q[0];
	assign prv_y = prv_q[1];
	assign prv_z = prv_q[2];
endmodule

[sv/vgrt_ctrl.sv]
// controller: sequences start, steps and answers, drives the emit strobe and the kind and hit bits
`timescale 1ns / 1ps
module vgrt_ctrl import vgrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic in_op,
	input  logic in_nonzero,
	input  logic out_busy,
	output logic accept_ok,
	output vgrt_cmd_t cmd,
	input  vgrt_sts_t sts,
	output logic emit,
	output logic emit_kind,
	output logic emit_hit
);
	typedef enum logic [2:0] {IDLE, DIV, SIDE, STEP, CHECK, REPORT} state_t;
	state_t state_q;
	logic active_q;

	// items are taken only while idle and the output slot is free
	assign accept_ok = state_q == IDLE && !out_busy && !emit;

	always_comb begin
		cmd = '0;
		cmd.load = in_fire && in_op == OP_START;
		cmd.div_step = state_q == DIV;
		cmd.side_init = state_q == SIDE;
		cmd.advance = state_q == STEP;
		cmd.check = state_q == CHECK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			active_q <= 1'b0;
			emit <= 1'b0;
			emit_kind <= 1'b0;
			emit_hit <= 1'b0;
		end else begin
			emit <= 1'b0;
			case (state_q)
				IDLE: begin
					if (in_fire) begin
						if (in_op == OP_START) begin
							active_q <= 1'b1;
							state_q <= DIV;
						end else if (active_q) begin
							if (in_nonzero) begin
								active_q <= 1'b0;
								emit <= 1'b1;
								emit_kind <= 1'b1;
								emit_hit <= 1'b1;
							end else begin
								state_q <= STEP;
							end
						end
					end
				end
				DIV: if (sts.div_done) state_q <= SIDE;
				SIDE: state_q <= STEP;
				STEP: state_q <= CHECK;
				CHECK: state_q <= REPORT;
				REPORT: begin
					emit <= 1'b1;
					emit_hit <= 1'b0;
					emit_kind <= sts.beyond;
					if (sts.beyond) active_q <= 1'b0;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_emit_one: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !$past(emit)) else $error("back to back emit");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == IDLE) else $error("accept while busy");
	a_report_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == REPORT |=> state_q == IDLE) else $error("report stuck");
`endif
endmodule

[sv/voxel_grid_ray_traversal.sv]
// top level: voxel grid ray traversal
// start word: 31 division steps, then side, step, check and report before the query
// answer word: a zero block runs step, check and report to the next query; a nonzero block reports a hit
// one word in flight; input stalls until the previous result word is taken
// arst_n clears control, reach resets to 8, no ray in flight
`timescale 1ns / 1ps
module voxel_grid_ray_traversal import vgrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic in_valid,
	output logic in_stall,
	input  logic op,
	input  logic signed [ORIGIN_BITS-1:0] origin_x,
	input  logic signed [ORIGIN_BITS-1:0] origin_y,
	input  logic signed [ORIGIN_BITS-1:0] origin_z,
	input  logic signed [DIR_BITS-1:0] dir_x,
	input  logic signed [DIR_BITS-1:0] dir_y,
	input  logic signed [DIR_BITS-1:0] dir_z,
	input  logic [BLOCK_BITS-1:0] block_value,
	output logic out_valid,
	input  logic out_stall,
	output logic kind,
	output logic signed [COORD_BITS-1:0] cell_x,
	output logic signed [COORD_BITS-1:0] cell_y,
	output logic signed [COORD_BITS-1:0] cell_z,
	output logic signed [COORD_BITS-1:0] prior_x,
	output logic signed [COORD_BITS-1:0] prior_y,
	output logic signed [COORD_BITS-1:0] prior_z,
	output logic [2:0] face,
	output logic hit
);
	logic [7:0] reach_q;
	logic accept_ok, in_fire, emit, emit_kind, emit_hit;
	vgrt_cmd_t cmd;
	vgrt_sts_t sts;
	logic [COORD_BITS-1:0] cx, cy, cz, px, py, pz;
	logic [2:0] fc;

	assign in_stall = !accept_ok;
	assign in_fire = in_valid && accept_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) reach_q <= 8'd8;
		else if (cfg_we) reach_q <= cfg_wdata;
	end

	vgrt_ctrl u_ctrl (.clk, .arst_n, .in_fire, .in_op(op),
		.in_nonzero(block_value != '0), .out_busy(out_valid), .accept_ok, .cmd, .sts,
		.emit, .emit_kind, .emit_hit);

	vgrt_datapath u_dp (.clk, .arst_n, .cmd, .sts, .max_reach(reach_q),
		.origin_x, .origin_y, .origin_z, .dir_x, .dir_y, .dir_z,
		.cur_x(cx), .cur_y(cy), .cur_z(cz), .prv_x(px), .prv_y(py), .prv_z(pz), .face(fc));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (emit) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind <= emit_kind;
			hit <= emit_hit;
			cell_x <= cx;
			cell_y <= cy;
			cell_z <= cz;
			prior_x <= px;
			prior_y <= py;
			prior_z <= pz;
			face <= fc;
		end
	end
endmodule

[dv/tb_voxel_grid_ray_traversal.sv]
// testbench for the voxel grid ray traversal block: table-driven directed part, then random rays
`timescale 1ns / 1ps
module tb_voxel_grid_ray_traversal;
	import vgrt_pkg::*;

	typedef logic [COORD_BITS-1:0] cell_t;

	typedef struct packed {
		logic op;
		logic signed [ORIGIN_BITS-1:0] ox, oy, oz;
		logic signed [DIR_BITS-1:0] dx, dy, dz;
		logic [BLOCK_BITS-1:0] blk;
	} word_t;

	typedef struct packed {
		logic kind;
		cell_t cx, cy, cz, px, py, pz;
		logic [2:0] face;
		logic hit;
	} report_t;

	typedef struct packed {
		word_t w;
		logic has_exp;
		report_t exp;
	} row_t;

	localparam int WATCHDOG = 20000;

	logic clk, arst_n, cfg_we;
	logic [7:0] cfg_wdata;
	logic in_valid, in_stall, out_valid, out_stall;
	logic op, kind, hit;
	logic signed [ORIGIN_BITS-1:0] origin_x, origin_y, origin_z;
	logic signed [DIR_BITS-1:0] dir_x, dir_y, dir_z;
	logic [BLOCK_BITS-1:0] block_value;
	logic signed [COORD_BITS-1:0] cell_x, cell_y, cell_z, prior_x, prior_y, prior_z;
	logic [2:0] face;

	voxel_grid_ray_traversal u_top (.*);

	// predictor state
	logic [7:0] reach;
	cell_t cur[3], prv[3], base[3];
	logic [DIST_BITS-1:0] side[3], delta[3];
	logic neg[3];
	logic in_flight;

	report_t report_q[$];
	int errors = 0, n_results = 0, n_hits = 0, n_miss = 0, n_words = 0;
	int table_errors = 0;
	int idle_cycles = 0;
	bit hold_rx = 0;
	bit random_gaps = 1;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic report_t make_report(logic k, logic h);
		report_t r;
		logic [2:0] f;
		cell_t d;
		f = FACE_PX;
		for (int a = 0; a < 3; a++) begin
			d = prv[a] - cur[a];
			if (d == cell_t'(1)) f = 3'(2 * a);
			if (d == '1) f = 3'(2 * a + 1);
		end
		r.kind = k; r.hit = h; r.face = f;
		r.cx = cur[0]; r.cy = cur[1]; r.cz = cur[2];
		r.px = prv[0]; r.py = prv[1]; r.pz = prv[2];
		return r;
	endfunction

	function automatic report_t dda_step();
		int ax;
		logic [DIST_BITS:0] s;
		longint sum, dd;
		longint cap;
		cell_t diff;
		prv = cur;
		if (side[0] < side[2] && side[0] < side[1]) ax = 0;
		else if (side[1] < side[0] && side[1] < side[2]) ax = 1;
		else ax = 2;
		s = {1'b0, side[ax]} + {1'b0, delta[ax]};
		side[ax] = s[DIST_BITS] ? DMAX : s[DIST_BITS-1:0];
		cur[ax] = neg[ax] ? cur[ax] - 1'b1 : cur[ax] + 1'b1;
		sum = 0;
		for (int a = 0; a < 3; a++) begin
			diff = cur[a] - base[a];
			dd = longint'($signed(diff));
			sum += dd * dd;
		end
		cap = 3 * longint'(reach) * longint'(reach);
		if (sum > cap) begin
			in_flight = 0;
			return make_report(1'b1, 1'b0);
		end
		return make_report(1'b0, 1'b0);
	endfunction

	// returns 1 when the word produces a report
	function automatic bit traverse(word_t w, output report_t r);
		longint o, d, f, mag, dl, sd;
		logic signed [ORIGIN_BITS-1:0] ov[3];
		logic signed [DIR_BITS-1:0] dv[3];
		r = '0;
		if (w.op == OP_START) begin
			ov[0] = w.ox; ov[1] = w.oy; ov[2] = w.oz;
			dv[0] = w.dx; dv[1] = w.dy; dv[2] = w.dz;
			for (int a = 0; a < 3; a++) begin
				o = ov[a]; d = dv[a];
				f = o & ((1 << FRAC_BITS) - 1);
				mag = d < 0 ? -d : d;
				dl = (mag == 0) ? longint'(DMAX) : (longint'(1) << 30) / mag;
				if (dl > longint'(DMAX)) dl = DMAX;
				if (d > 0) sd = (((1 << FRAC_BITS) - f) * dl) >>> FRAC_BITS;
				else sd = (f * dl) >>> FRAC_BITS;
				if (sd > longint'(DMAX)) sd = DMAX;
				base[a] = cell_t'((o - f) >>> FRAC_BITS);
				cur[a] = base[a];
				delta[a] = dl[DIST_BITS-1:0];
				side[a] = sd[DIST_BITS-1:0];
				neg[a] = !(d > 0);
			end
			in_flight = 1;
			r = dda_step();
			return 1;
		end
		if (!in_flight) return 0;
		if (w.blk != 0) begin
			in_flight = 0;
			r = make_report(1'b1, 1'b1);
			return 1;
		end
		r = dda_step();
		return 1;
	endfunction

	task automatic send(word_t w, bit has_exp = 0, report_t fixed = '0);
		report_t r;
		op <= w.op;
		origin_x <= w.ox; origin_y <= w.oy; origin_z <= w.oz;
		dir_x <= w.dx; dir_y <= w.dy; dir_z <= w.dz;
		block_value <= w.blk;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		n_words++;
		if (traverse(w, r)) begin
			report_q.push_back(r);
			if (has_exp && r != fixed) begin
				$error("directed row disagrees with predictor: exp %h got %h", fixed, r);
				table_errors++;
			end
		end
		@(negedge clk);
		if (random_gaps && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(1, 3))
				@(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (report_q.size() != 0) @(negedge clk);
		// an ignored answer may still be in the pipe
		repeat (45) @(negedge clk);
	endtask

	task automatic set_reach(logic [7:0] v);
		drain();
		cfg_we <= 1'b1; cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		reach = v;
	endtask

	function automatic word_t start_word(int ox, int oy, int oz, int dx, int dy, int dz);
		word_t w;
		w = '0;
		w.op = OP_START;
		w.ox = ORIGIN_BITS'(ox); w.oy = ORIGIN_BITS'(oy); w.oz = ORIGIN_BITS'(oz);
		w.dx = DIR_BITS'(dx); w.dy = DIR_BITS'(dy); w.dz = DIR_BITS'(dz);
		w.blk = BLOCK_BITS'($urandom);
		return w;
	endfunction

	function automatic word_t answer_word(int b);
		word_t w;
		w = '0;
		w.op = OP_ANSWER;
		w.ox = ORIGIN_BITS'($urandom); w.oy = ORIGIN_BITS'($urandom);
		w.oz = ORIGIN_BITS'($urandom);
		w.dx = DIR_BITS'($urandom); w.dy = DIR_BITS'($urandom); w.dz = DIR_BITS'($urandom);
		w.blk = BLOCK_BITS'(b);
		return w;
	endfunction

	function automatic int rand_dir();
		int v;
		case ($urandom_range(0, 4))
			0: v = 0;
			1: v = 16384;
			2: v = -16384;
			3: v = $urandom_range(1, 40);
			default: v = int'($urandom_range(0, 32768)) - 16384;
		endcase
		return v;
	endfunction

	function automatic int rand_origin();
		if ($urandom_range(0, 3) == 0) return $signed(19'($urandom));
		return int'($urandom_range(0, 8191)) - 4096;
	endfunction

	// output side: stall at random, check against oldest expectation
	always @(negedge clk) begin
		if (!arst_n) out_stall <= 1'b0;
		else if (hold_rx) out_stall <= 1'b1;
		else if (!random_gaps) out_stall <= 1'b0;
		else if ($urandom_range(0, 19) == 0) out_stall <= 1'b1;
		else if ($urandom_range(0, 2) == 0) out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		report_t e;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCHDOG) begin
				$display("watchdog: no word moved for %0d cycles", WATCHDOG);
				$display("FAILED: results differ");
				$finish;
			end
		end
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (report_q.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = report_q.pop_front();
				if (kind && hit) n_hits++;
				if (kind && !hit) n_miss++;
				if (kind !== e.kind) begin $error("kind exp %0d got %0d", e.kind, kind); errors++; end
				if (cell_x !== e.cx) begin $error("cell_x exp %0d got %0d", $signed(e.cx), cell_x); errors++; end
				if (cell_y !== e.cy) begin $error("cell_y exp %0d got %0d", $signed(e.cy), cell_y); errors++; end
				if (cell_z !== e.cz) begin $error("cell_z exp %0d got %0d", $signed(e.cz), cell_z); errors++; end
				if (prior_x !== e.px) begin $error("prior_x exp %0d got %0d", $signed(e.px), prior_x); errors++; end
				if (prior_y !== e.py) begin $error("prior_y exp %0d got %0d", $signed(e.py), prior_y); errors++; end
				if (prior_z !== e.pz) begin $error("prior_z exp %0d got %0d", $signed(e.pz), prior_z); errors++; end
				if (face !== e.face) begin $error("face exp %0d got %0d", e.face, face); errors++; end
				if (hit !== e.hit) begin $error("hit exp %0d got %0d", e.hit, hit); errors++; end
			end
		end
	end

	row_t dir_rows[$];

	function automatic report_t rep(logic k, int cx, int cy, int cz, int px, int py, int pz,
			logic [2:0] f, logic h);
		report_t r;
		r.kind = k; r.hit = h; r.face = f;
		r.cx = cell_t'(cx); r.cy = cell_t'(cy); r.cz = cell_t'(cz);
		r.px = cell_t'(px); r.py = cell_t'(py); r.pz = cell_t'(pz);
		return r;
	endfunction

	initial begin
		row_t row;
		word_t w;
		int steps;
		bit did_hold, did_r8, did_rr, did_seq, did_gap;
		did_hold = 0; did_r8 = 0; did_rr = 0; did_seq = 0; did_gap = 0;
		arst_n = 0; cfg_we = 0; cfg_wdata = 0; in_valid = 0;
		op = 0; origin_x = 0; origin_y = 0; origin_z = 0;
		dir_x = 0; dir_y = 0; dir_z = 0; block_value = 0;
		reach = 8; in_flight = 0;
		for (int a = 0; a < 3; a++) begin
			cur[a] = 0; prv[a] = 0; base[a] = 0; side[a] = 0; delta[a] = 0; neg[a] = 0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// answer right after reset: no ray, ignored
		dir_rows.push_back('{answer_word(0), 1'b0, '0});
		// all-zero direction from origin: ties go to z, step -z
		dir_rows.push_back('{start_word(0, 0, 0, 0, 0, 0), 1'b1,
			rep(0, 0, 0, -1, 0, 0, 0, FACE_PZ, 0)});
		dir_rows.push_back('{answer_word(7), 1'b1, rep(1, 0, 0, -1, 0, 0, 0, FACE_PZ, 1)});
		dir_rows.push_back('{answer_word(0), 1'b0, '0});
		// pure +x ray
		dir_rows.push_back('{start_word(128, 128, 128, 16384, 0, 0), 1'b1,
			rep(0, 1, 0, 0, 0, 0, 0, FACE_NX, 0)});
		dir_rows.push_back('{answer_word(0), 1'b0, '0});
		dir_rows.push_back('{answer_word(255), 1'b0, '0});
		// extremes of origin and direction
		dir_rows.push_back('{start_word(262143, -262144, 262143, -16384, 16384, -16384), 1'b0, '0});
		dir_rows.push_back('{answer_word(0), 1'b0, '0});
		dir_rows.push_back('{start_word(-262144, 262143, -262144, 16384, -16384, 1), 1'b0, '0});
		dir_rows.push_back('{answer_word(0), 1'b0, '0});
		dir_rows.push_back('{answer_word(1), 1'b0, '0});
		dir_rows.push_back('{start_word(-1, -1, -1, -1, -1, -1), 1'b0, '0});
		dir_rows.push_back('{start_word(255, 256, 0, 0, -16384, 0), 1'b0, '0});
		dir_rows.push_back('{answer_word(0), 1'b0, '0});
		dir_rows.push_back('{answer_word(128), 1'b0, '0});
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send(row.w, row.has_exp, row.exp);
		end

		// reach zero: first step misses
		set_reach(0);
		send(start_word(0, 0, 0, 16384, 0, 0));
		send(start_word(300, -20, 77, 100, -9000, 5));
		set_reach(255);
		send(start_word(0, 0, 0, 0, 0, 16384));
		for (int i = 0; i < 6; i++) send(answer_word(0));
		set_reach(1);

		// random rays: mostly full traversals with random content
		for (int n = 0; n < 900; ) begin
			if (n >= 300 && !did_hold) begin
				did_hold = 1;
				// long receiver hold-off while the sender keeps offering
				fork
					begin
						hold_rx = 1;
						repeat (200) @(negedge clk);
						hold_rx = 0;
					end
				join_none
			end
			if (n >= 450 && !did_r8) begin
				did_r8 = 1;
				set_reach(8);
			end
			if (n >= 600 && !did_rr) begin
				did_rr = 1;
				set_reach(8'(2 + $urandom_range(0, 30)));
			end
			if (n >= 750 && !did_seq) begin
				did_seq = 1;
				drain();
				random_gaps = 0;
			end
			if (n >= 820 && !did_gap) begin
				did_gap = 1;
				random_gaps = 1;
			end
			if ($urandom_range(0, 9) == 0) begin
				// noise: stray answer or broken ray
				w = answer_word($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : 0);
				send(w);
				n++;
				continue;
			end
			send(start_word(rand_origin(), rand_origin(), rand_origin(),
				rand_dir(), rand_dir(), rand_dir()));
			n++;
			steps = $urandom_range(0, 24);
			while (in_flight && steps > 0) begin
				send(answer_word($urandom_range(0, 15) == 0 ? $urandom_range(1, 255) : 0));
				n++; steps--;
			end
		end
		set_reach(8);

		in_valid <= 1'b0;
		drain();
		$display("covered %0d input words, %0d results (%0d hits, %0d misses)",
			n_words, n_results, n_hits, n_miss);
		$display("reach settings 0, 1, 8, 255 and random; long output hold-off included");
		if (errors == 0 && table_errors == 0 && report_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
